>>> design/hftd_pkg.sv
package hftd_pkg;

  localparam int unsigned MAX_NODES_DEF    = 512;
  localparam int unsigned MAX_CODE_LEN_DEF = 32;

  // stream and register port widths
  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 16;
  localparam int unsigned CFG_ADDR_W = 3;

  // register index, taken from paddr[2]
  localparam logic REG_TOTAL_SYMBOLS = 1'b0;

  typedef enum logic [1:0] {
    ST_SYMBOL  = 2'd0,
    ST_LOADED  = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_DECODE = 1'b1
  } op_e;

  // controller to datapath
  typedef struct packed {
    logic    accept;
    logic    rd_cur;
    logic    rd_walk;
    logic    rd_child;
    logic    wr_parent;
    logic    wr_zero;
    logic    wr_sym;
    logic    cur_follow;
    logic    res_en;
    status_e res_status;
    logic    walk_root;
    logic    walk_next;
    logic    cnt_inc;
    logic    adv_bit;
    logic    pend_load;
    logic    pend_clr;
    logic    out_push;
    logic    out_last;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic op_dec;
    logic len_zero;
    logic slot_zero;
    logic tbl_full;
    logic count_done;
    logic next_zero;
    logic is_leaf;
    logic last_bit;
    logic pend_valid;
    logic out_free;
  } sts_t;

endpackage

>>> design/huffman_tree_decoder_top.sv
// Load word: accept, then per code bit a node read and either a step to the existing child
// or a link write and clear of a new node; then final node read, symbol write, result
// release and item end. Decode word: accept, then per bit walked a count check, a node read
// and, unless the branch is missing, a child read, plus an emit step per result, then item
// end; the byte ends once the symbol count is reached. One item at a time; a stalled result
// port holds the walk. Reset is asynchronous: control, walk, counts and the register clear at
// once; the node memory is not swept, the root entry reads as empty until first written.
module huffman_tree_decoder_top #(
  parameter int unsigned MAX_NODES    = hftd_pkg::MAX_NODES_DEF,
  parameter int unsigned MAX_CODE_LEN = hftd_pkg::MAX_CODE_LEN_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // tdata: symbol_in[7:0], code_len[13:8], code_bits[45:14], data_byte[53:46], zero pad
  input  logic [hftd_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // tuser: op
  input  logic                             s_axis_tuser,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata: status[1:0], symbol_out[9:2], zero pad
  output logic [hftd_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  output logic                             m_axis_tlast,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [hftd_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import hftd_pkg::*;

  localparam int unsigned IW = $clog2(MAX_NODES);
  localparam int unsigned EW = 8 + 2 * IW;

  logic [31:0] total_q;
  cmd_t        cmd;
  sts_t        sts;
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic          ram_re;
  logic [IW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TOTAL_SYMBOLS) ? total_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else if (psel && penable && pwrite && (paddr[2] == REG_TOTAL_SYMBOLS)) begin
      total_q <= pwdata;
    end
  end

  hftd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hftd_datapath #(
    .MAX_NODES    (MAX_NODES),
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_op_i         (s_axis_tuser),
    .in_data_i       (s_axis_tdata),
    .total_symbols_i (total_q),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .ram_we_o        (ram_we),
    .ram_waddr_o     (ram_waddr),
    .ram_wdata_o     (ram_wdata),
    .ram_re_o        (ram_re),
    .ram_raddr_o     (ram_raddr),
    .ram_rdata_i     (ram_rdata),
    .out_tready_i    (m_axis_tready),
    .out_tvalid_o    (m_axis_tvalid),
    .out_tdata_o     (m_axis_tdata),
    .out_tlast_o     (m_axis_tlast)
  );

  hftd_ram #(
    .Width (EW),
    .Depth (MAX_NODES)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

>>> design/hftd_ram.sv
module hftd_ram #(
  parameter int unsigned Width = 26,
  parameter int unsigned Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/hftd_datapath.sv
module hftd_datapath #(
  parameter int unsigned MAX_NODES    = 512,
  parameter int unsigned MAX_CODE_LEN = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_op_i,
  input  logic [hftd_pkg::IN_DATA_W-1:0]      in_data_i,
  input  logic [31:0]                         total_symbols_i,
  input  hftd_pkg::cmd_t                      cmd_i,
  output hftd_pkg::sts_t                      sts_o,
  output logic                                ram_we_o,
  output logic [$clog2(MAX_NODES)-1:0]        ram_waddr_o,
  output logic [8+2*$clog2(MAX_NODES)-1:0]    ram_wdata_o,
  output logic                                ram_re_o,
  output logic [$clog2(MAX_NODES)-1:0]        ram_raddr_o,
  input  logic [8+2*$clog2(MAX_NODES)-1:0]    ram_rdata_i,
  input  logic                                out_tready_i,
  output logic                                out_tvalid_o,
  output logic [hftd_pkg::OUT_DATA_W-1:0]     out_tdata_o,
  output logic                                out_tlast_o
);
  import hftd_pkg::*;

  localparam int unsigned IW = $clog2(MAX_NODES);
  localparam int unsigned NW = $clog2(MAX_NODES + 1);
  localparam int unsigned CW = $clog2(MAX_CODE_LEN);
  localparam int unsigned LW = $clog2(MAX_CODE_LEN + 1);

  typedef struct packed {
    logic [7:0]    sym;
    logic [IW-1:0] right;
    logic [IW-1:0] left;
  } node_t;

  // input word fields
  logic [7:0]  in_sym;
  logic [5:0]  in_len;
  logic [31:0] in_code;
  logic [7:0]  in_byte;
  logic [LW-1:0] len_clamp;

  assign in_sym    = in_data_i[7:0];
  assign in_len    = in_data_i[13:8];
  assign in_code   = in_data_i[45:14];
  assign in_byte   = in_data_i[53:46];
  assign len_clamp = (32'(in_len) > 32'(MAX_CODE_LEN)) ? LW'(MAX_CODE_LEN) : LW'(in_len);

  // item registers
  op_e                   op_q;
  logic [7:0]            sym_q;
  logic [LW-1:0]         len_q, len_d;
  logic [MAX_CODE_LEN-1:0] code_q;
  logic [7:0]            byte_q;
  logic [2:0]            bit_q;
  logic [IW-1:0]         cur_q;
  logic [IW-1:0]         next_q;
  // tree and walk state
  logic [NW-1:0]         nodes_used_q;
  logic [IW-1:0]         walk_q;
  logic [31:0]           cnt_q;
  logic                  root_init_q;
  logic                  rd_root_q;
  // result staging
  status_e               res_status_q;
  logic [7:0]            res_sym_q;
  logic                  pend_valid_q;
  status_e               pend_status_q;
  logic [7:0]            pend_sym_q;
  logic                  out_valid_q;
  status_e               out_status_q;
  logic [7:0]            out_sym_q;
  logic                  out_last_q;

  node_t         node;
  node_t         wnode;
  logic [LW-1:0] len_m1;
  logic [CW-1:0] len_idx;
  logic          lbit;
  logic          dbit;
  logic [IW-1:0] slot;
  logic [IW-1:0] child;
  logic [IW-1:0] new_idx;
  logic          tbl_full;

  // the root entry is never cleared in memory: read it as empty until first written
  assign node = (rd_root_q && !root_init_q) ? '0 : node_t'(ram_rdata_i);

  assign len_m1   = len_q - LW'(1);
  assign len_idx  = len_m1[CW-1:0];
  assign lbit     = code_q[len_idx];
  assign dbit     = byte_q[bit_q];
  assign slot     = lbit ? node.right : node.left;
  assign child    = dbit ? node.right : node.left;
  assign new_idx  = nodes_used_q[IW-1:0];
  assign tbl_full = (nodes_used_q >= NW'(MAX_NODES));
  assign len_d    = len_q - LW'(1);

  // node memory access
  always_comb begin
    wnode       = node;
    ram_we_o    = 1'b0;
    ram_waddr_o = cur_q;
    if (cmd_i.wr_parent) begin
      ram_we_o = 1'b1;
      if (lbit) begin
        wnode.right = new_idx;
      end else begin
        wnode.left = new_idx;
      end
    end
    if (cmd_i.wr_zero) begin
      ram_we_o = 1'b1;
      wnode    = '0;
    end
    if (cmd_i.wr_sym) begin
      ram_we_o  = 1'b1;
      wnode.sym = sym_q;
    end
  end

  assign ram_wdata_o = wnode;
  assign ram_re_o    = cmd_i.rd_cur | cmd_i.rd_walk | cmd_i.rd_child;
  assign ram_raddr_o = cmd_i.rd_walk ? walk_q : (cmd_i.rd_child ? child : cur_q);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nodes_used_q <= NW'(1);
      walk_q       <= '0;
      cnt_q        <= '0;
      root_init_q  <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.wr_parent) begin
        nodes_used_q <= nodes_used_q + NW'(1);
      end
      if (ram_we_o && (ram_waddr_o == '0)) begin
        root_init_q <= 1'b1;
      end
      if (cmd_i.walk_root) begin
        walk_q <= '0;
      end else if (cmd_i.walk_next) begin
        walk_q <= next_q;
      end
      if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + 32'd1;
      end
      if (cmd_i.pend_load) begin
        pend_valid_q <= 1'b1;
      end else if (cmd_i.pend_clr) begin
        pend_valid_q <= 1'b0;
      end
      if (cmd_i.out_push) begin
        out_valid_q <= 1'b1;
      end else if (out_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q   <= op_e'(in_op_i);
      sym_q  <= in_sym;
      len_q  <= len_clamp;
      code_q <= MAX_CODE_LEN'(in_code);
      byte_q <= in_byte;
      bit_q  <= 3'd7;
      cur_q  <= '0;
    end else if (cmd_i.wr_parent) begin
      cur_q <= new_idx;
      len_q <= len_d;
    end else if (cmd_i.cur_follow) begin
      cur_q <= slot;
      len_q <= len_d;
    end
    if (cmd_i.adv_bit) begin
      bit_q <= bit_q - 3'd1;
    end
    if (ram_re_o) begin
      rd_root_q <= (ram_raddr_o == '0);
    end
    if (cmd_i.rd_child) begin
      next_q <= child;
    end
    if (cmd_i.res_en) begin
      res_status_q <= cmd_i.res_status;
      res_sym_q    <= (cmd_i.res_status == ST_SYMBOL) ? node.sym : 8'd0;
    end
    if (cmd_i.pend_load) begin
      pend_status_q <= res_status_q;
      pend_sym_q    <= res_sym_q;
    end
    if (cmd_i.out_push) begin
      out_status_q <= pend_status_q;
      out_sym_q    <= pend_sym_q;
      out_last_q   <= cmd_i.out_last;
    end
  end

  always_comb begin
    sts_o            = '0;
    sts_o.op_dec     = (op_q == OP_DECODE);
    sts_o.len_zero   = (len_q == '0);
    sts_o.slot_zero  = (slot == '0);
    sts_o.tbl_full   = tbl_full;
    sts_o.count_done = (cnt_q >= total_symbols_i);
    sts_o.next_zero  = (child == '0);
    sts_o.is_leaf    = (node.left == '0) && (node.right == '0);
    sts_o.last_bit   = (bit_q == 3'd0);
    sts_o.pend_valid = pend_valid_q;
    sts_o.out_free   = !out_valid_q || out_tready_i;
  end

  assign out_tvalid_o = out_valid_q;
  assign out_tdata_o  = {{(OUT_DATA_W-10){1'b0}}, out_sym_q, out_status_q};
  assign out_tlast_o  = out_last_q;

  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_push |-> (!out_valid_q || out_tready_i))
    else $error("result word overwritten while stalled");

  a_alloc_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_parent |-> !tbl_full)
    else $error("node allocated with a full table");

  a_new_node: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_parent |=> (cmd_i.wr_zero && (cur_q == IW'(nodes_used_q - NW'(1)))))
    else $error("new node not cleared after linking");

endmodule

>>> design/hftd_ctrl.sv
module hftd_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_op_i,
  output logic           in_ready_o,
  input  hftd_pkg::sts_t sts_i,
  output hftd_pkg::cmd_t cmd_o
);
  import hftd_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_LRD  = 9'b000000010,
    S_LEV  = 9'b000000100,
    S_LNEW = 9'b000001000,
    S_DCHK = 9'b000010000,
    S_DEV1 = 9'b000100000,
    S_DEV2 = 9'b001000000,
    S_EMIT = 9'b010000000,
    S_FIN  = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   moved;

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    in_ready_o = 1'b0;
    moved      = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = (op_e'(in_op_i) == OP_DECODE) ? S_DCHK : S_LRD;
        end
      end
      S_LRD: begin
        cmd_o.rd_cur = 1'b1;
        state_d = S_LEV;
      end
      S_LEV: begin
        if (sts_i.len_zero) begin
          cmd_o.wr_sym     = 1'b1;
          cmd_o.res_en     = 1'b1;
          cmd_o.res_status = ST_LOADED;
          state_d = S_EMIT;
        end else if (sts_i.slot_zero) begin
          if (sts_i.tbl_full) begin
            cmd_o.res_en     = 1'b1;
            cmd_o.res_status = ST_FULL;
            state_d = S_EMIT;
          end else begin
            cmd_o.wr_parent = 1'b1;
            state_d = S_LNEW;
          end
        end else begin
          cmd_o.cur_follow = 1'b1;
          state_d = S_LRD;
        end
      end
      S_LNEW: begin
        cmd_o.wr_zero = 1'b1;
        state_d = S_LRD;
      end
      S_DCHK: begin
        // stop the byte once the symbol count is reached
        if (sts_i.count_done) begin
          state_d = S_FIN;
        end else begin
          cmd_o.rd_walk = 1'b1;
          state_d = S_DEV1;
        end
      end
      S_DEV1: begin
        if (sts_i.next_zero) begin
          cmd_o.res_en     = 1'b1;
          cmd_o.res_status = ST_MISSING;
          cmd_o.walk_root  = 1'b1;
          state_d = S_EMIT;
        end else begin
          cmd_o.rd_child = 1'b1;
          state_d = S_DEV2;
        end
      end
      S_DEV2: begin
        if (sts_i.is_leaf) begin
          cmd_o.res_en     = 1'b1;
          cmd_o.res_status = ST_SYMBOL;
          cmd_o.cnt_inc    = 1'b1;
          cmd_o.walk_root  = 1'b1;
          state_d = S_EMIT;
        end else begin
          cmd_o.walk_next = 1'b1;
          if (sts_i.last_bit) begin
            state_d = S_FIN;
          end else begin
            cmd_o.adv_bit = 1'b1;
            state_d = S_DCHK;
          end
        end
      end
      S_EMIT: begin
        // older pending word goes out first; the new one waits for the next result or the item end
        if (!sts_i.pend_valid) begin
          cmd_o.pend_load = 1'b1;
          moved = 1'b1;
        end else if (sts_i.out_free) begin
          cmd_o.out_push  = 1'b1;
          cmd_o.pend_load = 1'b1;
          moved = 1'b1;
        end
        if (moved) begin
          if (!sts_i.op_dec || sts_i.last_bit) begin
            state_d = S_FIN;
          end else begin
            cmd_o.adv_bit = 1'b1;
            state_d = S_DCHK;
          end
        end
      end
      S_FIN: begin
        if (!sts_i.pend_valid) begin
          state_d = S_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.out_push = 1'b1;
          cmd_o.out_last = 1'b1;
          cmd_o.pend_clr = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !sts_i.pend_valid)
    else $error("pending word left behind at item end");

endmodule

>>> tb/testbench.sv
module testbench;
  import hftd_pkg::*;

  localparam int unsigned NODE_LIMIT = MAX_NODES_DEF;
  localparam int unsigned CODE_LIMIT = MAX_CODE_LEN_DEF;

  typedef struct {
    op_e         op;
    logic [7:0]  symbol;
    logic [5:0]  code_len;
    logic [31:0] code_bits;
    logic [7:0]  data_byte;
  } tree_op_t;

  typedef struct {
    status_e    status;
    logic [7:0] symbol;
    logic       last;
  } outcome_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  // tdata: symbol_in[7:0], code_len[13:8], code_bits[45:14], data_byte[53:46], zero pad
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  // tuser: op
  logic                  s_axis_tuser = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // tdata: status[1:0], symbol_out[9:2], zero pad
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  huffman_tree_decoder_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #6 clk_i = ~clk_i;

  // shadow of the node table and the walk
  logic [8:0]  left_link [NODE_LIMIT];
  logic [8:0]  right_link [NODE_LIMIT];
  logic [7:0]  node_sym [NODE_LIMIT];
  logic [9:0]  node_count;
  logic [8:0]  walk_pos;
  logic [31:0] decoded_count;
  logic [31:0] symbol_limit;

  tree_op_t tree_ops_q[$];
  outcome_t due_outcomes[$];
  tree_op_t on_wire;
  outcome_t want;
  logic     in_fire = 1'b0;
  int       ops_queued = 0;
  int       ops_taken = 0;
  int       send_gap_pct = 0;
  int       ready_stall_pct = 0;
  int       fail_count = 0;
  int       loads_taken = 0;
  int       bytes_taken = 0;
  int       sym_results = 0;
  int       missing_results = 0;
  int       full_results = 0;

  task automatic grow_path(input tree_op_t op_in);
    outcome_t   one;
    logic [8:0] cur;
    logic [8:0] nxt;
    int         eff_len;
    int         pos;
    cur = '0;
    one.status = ST_LOADED;
    one.symbol = '0;
    one.last = 1'b1;
    eff_len = (op_in.code_len > CODE_LIMIT) ? CODE_LIMIT : op_in.code_len;
    for (pos = eff_len - 1; pos >= 0; pos--) begin
      nxt = op_in.code_bits[pos] ? right_link[cur] : left_link[cur];
      if (nxt == 0) begin
        // keep nodes created so far, drop the symbol
        if (node_count >= NODE_LIMIT) begin
          one.status = ST_FULL;
          break;
        end
        nxt = node_count[8:0];
        if (op_in.code_bits[pos]) right_link[cur] = nxt;
        else left_link[cur] = nxt;
        left_link[nxt] = '0;
        right_link[nxt] = '0;
        node_sym[nxt] = '0;
        node_count = node_count + 10'd1;
      end
      cur = nxt;
    end
    if (one.status == ST_LOADED) node_sym[cur] = op_in.symbol;
    due_outcomes.push_back(one);
  endtask

  task automatic walk_byte(input tree_op_t op_in);
    outcome_t   fresh[$];
    outcome_t   one;
    logic [8:0] nxt;
    int         k;
    for (k = 7; k >= 0; k--) begin
      if (decoded_count >= symbol_limit) break;
      nxt = op_in.data_byte[k] ? right_link[walk_pos] : left_link[walk_pos];
      if (nxt == 0) begin
        one.status = ST_MISSING;
        one.symbol = '0;
        walk_pos = '0;
      end else if (left_link[nxt] == 0 && right_link[nxt] == 0) begin
        one.status = ST_SYMBOL;
        one.symbol = node_sym[nxt];
        decoded_count = decoded_count + 32'd1;
        walk_pos = '0;
      end else begin
        walk_pos = nxt;
        continue;
      end
      one.last = 1'b0;
      fresh.push_back(one);
    end
    if (fresh.size() != 0) fresh[fresh.size() - 1].last = 1'b1;
    foreach (fresh[i]) due_outcomes.push_back(fresh[i]);
  endtask

  // accept input words, predict, and check output words
  always @(posedge clk_i) begin
    in_fire = 1'b0;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_fire = 1'b1;
        ops_taken++;
        if (on_wire.op == OP_LOAD) begin
          loads_taken++;
          grow_path(on_wire);
        end else begin
          bytes_taken++;
          walk_byte(on_wire);
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_outcomes.size() == 0) begin
          $error("unexpected word: status %0d, symbol_out %0d, last %0d",
                 m_axis_tdata[1:0], m_axis_tdata[9:2], m_axis_tlast);
          fail_count++;
        end else begin
          want = due_outcomes.pop_front();
          if (m_axis_tdata[1:0] !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_axis_tdata[1:0]);
            fail_count++;
          end
          if (m_axis_tdata[9:2] !== want.symbol) begin
            $error("symbol_out: expected %0d, got %0d", want.symbol, m_axis_tdata[9:2]);
            fail_count++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, m_axis_tlast);
            fail_count++;
          end
          case (want.status)
            ST_SYMBOL:  sym_results++;
            ST_MISSING: missing_results++;
            ST_FULL:    full_results++;
            default:    ;
          endcase
        end
      end
    end
  end

  // drive the next word once the current one is taken
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      if (!s_axis_tvalid || in_fire) begin
        if (tree_ops_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          on_wire = tree_ops_q.pop_front();
          s_axis_tdata <= {2'b00, on_wire.data_byte, on_wire.code_bits,
                           on_wire.code_len, on_wire.symbol};
          s_axis_tuser <= on_wire.op;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= ready_stall_pct);
    end
  end

  function automatic tree_op_t make_load(input logic [7:0] sym, input logic [5:0] len,
                                         input logic [31:0] code);
    tree_op_t t;
    t.op = OP_LOAD;
    t.symbol = sym;
    t.code_len = len;
    t.code_bits = code;
    t.data_byte = 8'($urandom_range(255));
    return t;
  endfunction

  function automatic tree_op_t make_decode(input logic [7:0] value);
    tree_op_t t;
    t.op = OP_DECODE;
    t.symbol = 8'($urandom_range(255));
    t.code_len = 6'($urandom_range(63));
    t.code_bits = $urandom;
    t.data_byte = value;
    return t;
  endfunction

  task automatic enqueue(input tree_op_t t);
    tree_ops_q.push_back(t);
    ops_queued++;
  endtask

  // hold until every word is taken and every result is back
  task automatic quiesce(input int extra);
    do @(negedge clk_i); while (ops_taken != ops_queued || due_outcomes.size() != 0);
    repeat (extra) @(negedge clk_i);
  endtask

  task automatic set_symbol_limit(input logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_TOTAL_SYMBOLS, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite <= 1'b0;
    symbol_limit = value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== value) begin
      $error("total_symbols: expected %0h, got %0h", value, prdata);
      fail_count++;
    end
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [5:0] pick_code_len(input int phase);
    int r;
    r = $urandom_range(99);
    if (phase == 3 && r < 50) return 6'($urandom_range(24, 32));
    if (r < 5) return 6'd0;
    if (r < 10) return 6'($urandom_range(32, 63));
    if (r < 15) return 6'($urandom_range(17, 31));
    if (r < 30) return 6'($urandom_range(9, 16));
    return 6'($urandom_range(1, 8));
  endfunction

  // bytes whose bits follow existing branches from the current walk position
  task automatic queue_clean_bytes(input int count);
    logic [8:0] node;
    logic [8:0] nxt;
    logic [7:0] value;
    logic       pick;
    int         n;
    int         k;
    node = walk_pos;
    for (n = 0; n < count; n++) begin
      for (k = 7; k >= 0; k--) begin
        if (left_link[node] != 0 && right_link[node] != 0) pick = 1'($urandom_range(1));
        else if (right_link[node] != 0) pick = 1'b1;
        else if (left_link[node] != 0) pick = 1'b0;
        else pick = 1'($urandom_range(1));
        value[k] = pick;
        nxt = pick ? right_link[node] : left_link[node];
        if (nxt == 0 || (left_link[nxt] == 0 && right_link[nxt] == 0)) node = '0;
        else node = nxt;
      end
      enqueue(make_decode(value));
    end
  endtask

  initial begin
    int phase;
    int batch;
    int k;
    for (k = 0; k < NODE_LIMIT; k++) begin
      left_link[k] = '0;
      right_link[k] = '0;
      node_sym[k] = '0;
    end
    node_count = 10'd1;
    walk_pos = '0;
    decoded_count = '0;
    symbol_limit = '0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // count already reached, then a small prefix code plus odd lengths
    set_symbol_limit(32'h0000_0000);
    enqueue(make_decode(8'hFF));
    enqueue(make_load(8'h41, 6'd1, 32'h0));
    enqueue(make_load(8'h42, 6'd2, 32'h2));
    enqueue(make_load(8'h43, 6'd3, 32'h6));
    enqueue(make_load(8'hFF, 6'd3, 32'h7));
    enqueue(make_load(8'h00, 6'd0, $urandom));
    enqueue(make_load(8'h55, 6'd63, 32'hFFFF_FFFF));
    enqueue(make_load(8'h66, 6'd2, 32'h2));
    quiesce(64);
    set_symbol_limit(32'd5);
    enqueue(make_decode(8'h00));
    quiesce(64);
    set_symbol_limit(32'hFFFF_FFFF);
    enqueue(make_decode(8'h00));
    enqueue(make_decode(8'hE0));
    for (k = 0; k < 4; k++) enqueue(make_decode(8'hFF));
    enqueue(make_decode(8'h80));
    enqueue(make_decode(8'hC0));
    enqueue(make_load(8'h7E, 6'd4, 32'hD));
    enqueue(make_decode(8'hD0));
    enqueue(make_decode(8'hC0));

    for (phase = 0; phase < 4; phase++) begin
      quiesce(64);
      case (phase)
        0: begin
          set_symbol_limit(32'hFFFF_FFFF);
          send_gap_pct = 0;
          ready_stall_pct = 0;
        end
        1: begin
          set_symbol_limit(32'h8000_0000);
          send_gap_pct = 84;
          ready_stall_pct = 0;
        end
        2: begin
          set_symbol_limit(32'h7FFF_FFFF);
          send_gap_pct = 0;
          ready_stall_pct = 84;
        end
        default: begin
          set_symbol_limit(32'h0001_0000);
          send_gap_pct = 12;
          ready_stall_pct = 12;
        end
      endcase
      for (batch = 0; batch < 5; batch++) begin
        for (k = 0; k < 10; k++) begin
          if ($urandom_range(9) < 6)
            enqueue(make_load(8'($urandom_range(255)), pick_code_len(phase), $urandom));
          else
            enqueue(make_decode(8'($urandom_range(255))));
        end
        quiesce(0);
        queue_clean_bytes(12);
      end
    end

    // stop the count partway through a run of bytes
    quiesce(64);
    set_symbol_limit(decoded_count + 32'd12);
    queue_clean_bytes(10);
    enqueue(make_load(8'($urandom_range(255)), 6'($urandom_range(1, 8)), $urandom));
    queue_clean_bytes(2);
    quiesce(64);

    $display("Ran %0d loads and %0d decode bytes: %0d symbols, %0d missing branches, %0d full.",
             loads_taken, bytes_taken, sym_results, missing_results, full_results);
    $display("Node table ended with %0d of %0d nodes; symbol limit went from zero to all ones.",
             node_count, NODE_LIMIT);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #12000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

>>> filelist.f
design/hftd_pkg.sv
design/hftd_ram.sv
design/hftd_datapath.sv
design/hftd_ctrl.sv
design/huffman_tree_decoder_top.sv
tb/testbench.sv
